// ===== hdl/pursuit_steering_command_core_assert.svh =====
// ---------------------------------------------------------------------------
// pursuit steering command assertion macros
// shared concurrent assertion forms, clocked on clk
// ---------------------------------------------------------------------------
`ifndef PURSUIT_STEERING_COMMAND_CORE_ASSERT_SVH
`define PURSUIT_STEERING_COMMAND_CORE_ASSERT_SVH

// checked only while out of reset
`define PSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also during reset
`define PSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/psc_pkg.sv =====
// ---------------------------------------------------------------------------
// psc_pkg
// constants, tables and types of the pursuit steering command block
// ---------------------------------------------------------------------------
package psc_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CORDIC_STEPS   = 14;
  localparam int ANGLE_W        = 15;
  localparam int VEL_W          = 13;
  localparam int ROT_W          = 14;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 15'd25723;
  localparam logic [ANGLE_W-1:0] HALF_PI_UNITS = 15'd12868;
  localparam logic [ANGLE_W-1:0] PI6_UNITS     = 15'd4288;

  // squared full angle, 30 bits
  localparam logic [29:0] ANGLE_MAX_SQ = 30'(64'd25723 * 64'd25723);
  // floor(2^42 / ANGLE_MAX) for division of the root by ANGLE_MAX
  localparam int          RECIP_SHIFT  = 42;
  localparam logic [27:0] RECIP_A      = 28'((64'd1 << RECIP_SHIFT) / 64'd25723);

  localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'd6434, 16'd3798, 16'd2007, 16'd1019, 16'd511, 16'd256, 16'd128,
    16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1
  };

  // ceil(2^17 / d); entry 0 stands for a divisor of one
  localparam int DIV_SHIFT = 17;
  localparam logic [17:0] DIV_RECIP [16] = '{
    18'd131072, 18'd131072, 18'd65536, 18'd43691, 18'd32768, 18'd26215,
    18'd21846, 18'd18725, 18'd16384, 18'd14564, 18'd13108, 18'd11916,
    18'd10923, 18'd10083, 18'd9363, 18'd8739
  };

  typedef enum logic [1:0] {
    REG_MAX_ROT   = 2'd0,
    REG_MAX_TRANS = 2'd1,
    REG_DIVISOR   = 2'd2,
    REG_STOP      = 2'd3
  } reg_idx_t;

  localparam logic [12:0] MAX_ROT_RST   = 13'd2048;
  localparam logic [12:0] MAX_TRANS_RST = 13'd410;
  localparam logic [3:0]  DIVISOR_RST   = 4'd5;
  localparam logic [11:0] STOP_RST      = 12'd150;

endpackage

// ===== hdl/psc_if.sv =====
// ---------------------------------------------------------------------------
// psc channel interfaces
// valid/ready channels for steering requests and steering commands
// ---------------------------------------------------------------------------
interface psc_in_if import psc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] robot_x;
  logic [COORD_BITS-1:0] robot_y;
  logic signed [COORD_BITS:0] heading_dx;
  logic signed [COORD_BITS:0] heading_dy;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;
  logic [11:0]           front_range_mm;

  modport source (output valid, robot_x, robot_y, heading_dx, heading_dy, target_x,
                  target_y, front_range_mm, input ready);
  modport sink (input valid, robot_x, robot_y, heading_dx, heading_dy, target_x,
                target_y, front_range_mm, output ready);
endinterface

interface psc_out_if import psc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [ROT_W-1:0]  rotation_velocity;
  logic [VEL_W-1:0]         translation_velocity;
  logic [ANGLE_W-1:0]       turn_angle;

  modport source (output valid, rotation_velocity, translation_velocity, turn_angle,
                  input ready);
  modport sink (input valid, rotation_velocity, translation_velocity, turn_angle,
                output ready);
endinterface

// ===== hdl/psc_cordic.sv =====
// ---------------------------------------------------------------------------
// psc_cordic
// pipelined vectoring cordic: angle between heading and target vector
// ---------------------------------------------------------------------------
module psc_cordic import psc_pkg::*; #(
  parameter int DW = 2 * COORD_BITS_DEF + 3
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [DW-1:0] dot_i,
  input  logic signed [DW-1:0] cross_i,
  input  logic                zero_i,
  output logic [ANGLE_W-1:0]  angle_o
);

  localparam int CW = DW + 18;

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [16:0]   z_r [CORDIC_STEPS+1];
  logic                 spec_r [CORDIC_STEPS+1];
  logic [ANGLE_W-1:0]   spval_r [CORDIC_STEPS+1];
  logic [ANGLE_W-1:0]   angle_r;

  logic signed [DW:0]   crs_e;
  logic signed [DW:0]   cabs;
  logic signed [CW-1:0] dot_w;
  logic signed [CW-1:0] cabs_w;

  always_comb begin
    crs_e  = {cross_i[DW-1], cross_i};
    cabs   = crs_e[DW] ? -crs_e : crs_e;
    dot_w  = {{(CW-DW-16){dot_i[DW-1]}}, dot_i, 16'd0};
    cabs_w = {{(CW-DW-17){1'b0}}, cabs, 16'd0};
  end

  // prerotate by 90 degrees when the target lies behind
  always_ff @(posedge clk) begin
    if (en) begin
      if (dot_i[DW-1]) begin
        x_r[0] <= cabs_w;
        y_r[0] <= -dot_w;
        z_r[0] <= 17'($unsigned(HALF_PI_UNITS));
      end else begin
        x_r[0] <= dot_w;
        y_r[0] <= cabs_w;
        z_r[0] <= '0;
      end
      spec_r[0]  <= zero_i || (cross_i == '0);
      spval_r[0] <= (!zero_i && (dot_i <= 0)) ? ANGLE_MAX : '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + 17'(ATAN_TAB[i]);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - 17'(ATAN_TAB[i]);
        end
        spec_r[i+1]  <= spec_r[i];
        spval_r[i+1] <= spval_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (spec_r[CORDIC_STEPS]) begin
        angle_r <= spval_r[CORDIC_STEPS];
      end else if (z_r[CORDIC_STEPS][16]) begin
        angle_r <= '0;
      end else if (z_r[CORDIC_STEPS] > 17'($unsigned(ANGLE_MAX))) begin
        angle_r <= ANGLE_MAX;
      end else begin
        angle_r <= z_r[CORDIC_STEPS][ANGLE_W-1:0];
      end
    end
  end

  assign angle_o = angle_r;

endmodule

// ===== hdl/psc_isqrt.sv =====
// ---------------------------------------------------------------------------
// psc_isqrt
// pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
module psc_isqrt import psc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [55:0] n_i,
  output logic [27:0] root_o
);

  localparam int STEPS = 28;

  logic [55:0] n_r [STEPS];
  logic [29:0] r_r [STEPS];
  logic [27:0] q_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [55:0] n_prev;
    logic [29:0] r_prev;
    logic [27:0] q_prev;
    logic [31:0] cur;
    logic [31:0] trial;

    if (i == 0) begin : g_first
      assign n_prev = n_i;
      assign r_prev = '0;
      assign q_prev = '0;
    end else begin : g_next
      assign n_prev = n_r[i-1];
      assign r_prev = r_r[i-1];
      assign q_prev = q_r[i-1];
    end

    always_comb begin
      cur   = {r_prev, n_prev[55:54]};
      trial = {2'b00, q_prev, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= {n_prev[53:0], 2'b00};
        if (cur >= trial) begin
          r_r[i] <= 30'(cur - trial);
          q_r[i] <= {q_prev[26:0], 1'b1};
        end else begin
          r_r[i] <= cur[29:0];
          q_r[i] <= {q_prev[26:0], 1'b0};
        end
      end
    end
  end

  assign root_o = q_r[STEPS-1];

endmodule

// ===== hdl/pursuit_steering_command_core.sv =====
// ---------------------------------------------------------------------------
// pursuit_steering_command_core
// turning angle, rotation and forward speed commands toward a target
// ---------------------------------------------------------------------------
// The core takes one steering request per clock while the output side does
// not stall and returns one command per request, in order. The requests pass
// through the angle cordic and the 28-stage square root of the forward speed
// path; the whole pipeline holds when a finished command waits at the output.
// Registers are written through the APB-style port; the user is to write them
// only between bursts of traffic, which the block itself does not enforce.
module pursuit_steering_command_core import psc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  psc_in_if.sink      in_ch,
  psc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DW      = 2 * COORD_BITS + 3;
  localparam int ANG_STG = 16;
  localparam int LAT     = 51;
  localparam int TAIL_N  = 33;

  typedef struct packed {
    logic dir_neg;
    logic blocked;
  } side_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] rot;
    logic [ANGLE_W-1:0]      angle;
    logic                    blocked;
  } tail_t;

  // configuration
  logic [12:0] max_rot_r;
  logic [12:0] max_trans_r;
  logic [3:0]  divisor_r;
  logic [11:0] stop_r;
  logic [25:0] trans_sq_r;
  logic [30:0] rot_prod_r;
  logic [12:0] rot_small_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rot_r   <= MAX_ROT_RST;
      max_trans_r <= MAX_TRANS_RST;
      divisor_r   <= DIVISOR_RST;
      stop_r      <= STOP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_ROT:   max_rot_r   <= cfg_pwdata[12:0];
        REG_MAX_TRANS: max_trans_r <= cfg_pwdata[12:0];
        REG_DIVISOR:   divisor_r   <= cfg_pwdata[3:0];
        REG_STOP:      stop_r      <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_ROT:   cfg_prdata = {19'd0, max_rot_r};
      REG_MAX_TRANS: cfg_prdata = {19'd0, max_trans_r};
      REG_DIVISOR:   cfg_prdata = {28'd0, divisor_r};
      REG_STOP:      cfg_prdata = {20'd0, stop_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // derived constants are registered: trans_sq_r from max_trans_r, rot_small_r via rot_prod_r
  always_ff @(posedge clk) begin
    trans_sq_r  <= max_trans_r * max_trans_r;
    rot_prod_r  <= max_rot_r * DIV_RECIP[divisor_r];
    rot_small_r <= rot_prod_r[DIV_SHIFT+12:DIV_SHIFT];
  end

  // pipeline control
  logic [LAT-1:0] vld_r;
  logic           en;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // stage 0: vectors, dot and cross products
  logic signed [COORD_BITS:0]     vx, vy;
  logic signed [COORD_BITS+1:0]   dsub;
  logic signed [2*COORD_BITS+1:0] p_xx, p_yy, p_xy, p_yx;
  logic signed [DW-1:0]           dot_w, cross_w;
  logic                           zero_w, dir_neg_w;

  always_comb begin
    vx      = $signed({1'b0, in_ch.target_x}) - $signed({1'b0, in_ch.robot_x});
    vy      = $signed({1'b0, in_ch.target_y}) - $signed({1'b0, in_ch.robot_y});
    p_xx    = vx * in_ch.heading_dx;
    p_yy    = vy * in_ch.heading_dy;
    p_xy    = vx * in_ch.heading_dy;
    p_yx    = vy * in_ch.heading_dx;
    dot_w   = {p_xx[2*COORD_BITS+1], p_xx} + {p_yy[2*COORD_BITS+1], p_yy};
    cross_w = {p_xy[2*COORD_BITS+1], p_xy} - {p_yx[2*COORD_BITS+1], p_yx};
    zero_w  = ((vx == '0) && (vy == '0)) ||
              ((in_ch.heading_dx == '0) && (in_ch.heading_dy == '0));
    dsub    = {vx[COORD_BITS], vx} -
              {in_ch.heading_dx[COORD_BITS], in_ch.heading_dx};
    // sign of heading_dy * (vx - heading_dx)
    dir_neg_w = (in_ch.heading_dy != '0) && (dsub != '0) &&
                (in_ch.heading_dy[COORD_BITS] ^ dsub[COORD_BITS+1]);
  end

  logic signed [DW-1:0] dot_r, cross_r;
  logic                 zero_r;
  side_t                side_r [ANG_STG+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r             <= dot_w;
      cross_r           <= cross_w;
      zero_r            <= zero_w;
      side_r[0].dir_neg <= dir_neg_w;
      side_r[0].blocked <= in_ch.front_range_mm < stop_r;
      for (int k = 1; k <= ANG_STG; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stages 1..16: angle
  logic [ANGLE_W-1:0] angle;

  psc_cordic #(.DW(DW)) u_cordic (
    .clk     (clk),
    .en      (en),
    .dot_i   (dot_r),
    .cross_i (cross_r),
    .zero_i  (zero_r),
    .angle_o (angle)
  );

  // stage 17: remaining angle term and rotation command
  logic [29:0]          a_sq;
  logic [12:0]          rot_mag;
  logic signed [ROT_W-1:0] rot_w;
  logic [29:0]          rem_r;
  tail_t                tail_r [TAIL_N];

  always_comb begin
    a_sq    = angle * angle;
    rot_mag = (angle < PI6_UNITS) ? rot_small_r : max_rot_r;
    rot_w   = side_r[ANG_STG].dir_neg ? -$signed({1'b0, rot_mag})
                                      : $signed({1'b0, rot_mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r             <= ANGLE_MAX_SQ - a_sq;
      tail_r[0].rot     <= rot_w;
      tail_r[0].angle   <= angle;
      tail_r[0].blocked <= side_r[ANG_STG].blocked;
      for (int k = 1; k < TAIL_N; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
    end
  end

  // stages 18, 19: rem * max_translation^2 in two partial products
  logic [40:0] p_hi_r, p_lo_r;
  logic [55:0] sq_in_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi_r  <= rem_r[29:15] * trans_sq_r;
      p_lo_r  <= rem_r[14:0] * trans_sq_r;
      sq_in_r <= {p_hi_r, 15'd0} + {15'd0, p_lo_r};
    end
  end

  // stages 20..47: square root
  logic [27:0] root;

  psc_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .n_i    (sq_in_r),
    .root_o (root)
  );

  // stages 48..50: divide the root by the full angle
  logic [55:0] dprod_r;
  logic [27:0] root_d1_r, root_d2_r;
  logic [13:0] qe_r;
  logic [28:0] qa_r;
  logic [28:0] diff;
  logic [13:0] quot;

  logic signed [ROT_W-1:0] out_rot_r;
  logic [VEL_W-1:0]        out_trans_r;
  logic [ANGLE_W-1:0]      out_angle_r;

  always_comb begin
    diff = {1'b0, root_d2_r} - qa_r;
    quot = (diff >= 29'(ANGLE_MAX)) ? qe_r + 14'd1 : qe_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dprod_r     <= root * RECIP_A;
      root_d1_r   <= root;
      qe_r        <= dprod_r[RECIP_SHIFT+13:RECIP_SHIFT];
      qa_r        <= dprod_r[RECIP_SHIFT+13:RECIP_SHIFT] * ANGLE_MAX;
      root_d2_r   <= root_d1_r;
      out_rot_r   <= tail_r[TAIL_N-1].rot;
      out_angle_r <= tail_r[TAIL_N-1].angle;
      out_trans_r <= tail_r[TAIL_N-1].blocked ? '0 : quot[VEL_W-1:0];
    end
  end

  assign out_ch.valid                = vld_r[LAT-1];
  assign out_ch.rotation_velocity    = out_rot_r;
  assign out_ch.translation_velocity = out_trans_r;
  assign out_ch.turn_angle           = out_angle_r;

endmodule

// ===== hdl/psc_checker.sv =====
// ---------------------------------------------------------------------------
// psc_checker
// port-level checks of the pursuit steering command core
// ---------------------------------------------------------------------------
`include "pursuit_steering_command_core_assert.svh"

module psc_checker import psc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ROT_W-1:0] out_rot,
  input logic [VEL_W-1:0]        out_trans,
  input logic [ANGLE_W-1:0]      out_angle
);

  `PSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rot) && $stable(out_trans) && $stable(out_angle), "stalled command changed")
  `PSC_ASSERT(a_take_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `PSC_ASSERT(a_angle_range, out_valid |-> out_angle <= ANGLE_MAX, "turn angle out of range")
  `PSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "command valid after reset")

endmodule

bind pursuit_steering_command_core psc_checker u_psc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rot   (out_ch.rotation_velocity),
  .out_trans (out_ch.translation_velocity),
  .out_angle (out_ch.turn_angle)
);

// ===== tb/tb_pursuit_steering_command_core.sv =====
// ---------------------------------------------------------------------------
// tb_pursuit_steering_command_core
// self-checking bench for the pursuit steering command core: a directed table
// and random traffic under several idle/stall mixes and register settings,
// every command compared field by field with its typed table entry or an in-bench steering predictor
// ---------------------------------------------------------------------------
module tb_pursuit_steering_command_core;
  import psc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0]         rx, ry, tx, ty;
    logic signed [10:0] hx, hy;
    logic [11:0]        range_mm;
  } request_t;

  typedef struct {
    logic [ROT_W-1:0]   rot;
    logic [VEL_W-1:0]   trans;
    logic [ANGLE_W-1:0] angle;
  } command_t;

  typedef struct {
    request_t req;
    bit       typed;
    command_t cmd;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  psc_in_if  in_ch();
  psc_out_if out_ch();

  pursuit_steering_command_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic [12:0] max_rot_q, max_trans_q;
  logic [3:0]  divisor_q;
  logic [11:0] stop_mm_q;

  command_t pending_cmds[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint unsigned isqrt_u64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring cordic on (dot, |cross|), both scaled by 2^16
  function automatic longint cordic_angle(longint dot, longint crs);
    longint x, y, z, t, nx, ny;
    z = 0;
    if (crs == 0) return (dot > 0) ? 0 : longint'(ANGLE_MAX);
    x = dot * 65536;
    y = ((crs < 0) ? -crs : crs) * 65536;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(HALF_PI_UNITS);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > longint'(ANGLE_MAX)) z = longint'(ANGLE_MAX);
    return z;
  endfunction

  function automatic command_t steer_command(request_t r);
    command_t c;
    longint vx, vy, hx, hy, ang, mag, rot;
    longint unsigned a, rem, trans, div, mt;
    vx = longint'(r.tx) - longint'(r.rx);
    vy = longint'(r.ty) - longint'(r.ry);
    hx = r.hx;
    hy = r.hy;
    if ((vx == 0 && vy == 0) || (hx == 0 && hy == 0)) ang = 0;
    else ang = cordic_angle(vx * hx + vy * hy, vx * hy - vy * hx);
    mag = max_rot_q;
    if (ang < longint'(PI6_UNITS)) begin
      div = (divisor_q == 0) ? 1 : divisor_q;
      mag = mag / longint'(div);
    end
    rot = (hy * (vx - hx) < 0) ? -mag : mag;
    a = ang;
    mt = max_trans_q;
    rem = 64'd25723 * 64'd25723 - a * a;
    trans = isqrt_u64(rem * mt * mt) / 64'd25723;
    if (r.range_mm < stop_mm_q) trans = 0;
    c.rot = rot[ROT_W-1:0];
    c.trans = trans[VEL_W-1:0];
    c.angle = ang[ANGLE_W-1:0];
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result side: random stall and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    command_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.turn_angle, -1);
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.rotation_velocity !== want.rot)
          report_mismatch("rotation", $signed(out_ch.rotation_velocity), $signed(want.rot));
        if (out_ch.translation_velocity !== want.trans)
          report_mismatch("translation", out_ch.translation_velocity, want.trans);
        if (out_ch.turn_angle !== want.angle)
          report_mismatch("angle", out_ch.turn_angle, want.angle);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(idx) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_MAX_ROT:   max_rot_q   = value[12:0];
      REG_MAX_TRANS: max_trans_q = value[12:0];
      REG_DIVISOR:   divisor_q   = value[3:0];
      REG_STOP:      stop_mm_q   = value[11:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [12:0] mr, logic [12:0] mt, logic [3:0] dv,
                                logic [11:0] st);
    write_reg(REG_MAX_ROT, 32'(mr));
    write_reg(REG_MAX_TRANS, 32'(mt));
    write_reg(REG_DIVISOR, 32'(dv));
    write_reg(REG_STOP, 32'(st));
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // called right after a posedge; leaves valid high after the accepting edge
  task automatic send_request(request_t r, bit typed, command_t typed_cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.robot_x        <= r.rx;
    in_ch.robot_y        <= r.ry;
    in_ch.heading_dx     <= r.hx;
    in_ch.heading_dy     <= r.hy;
    in_ch.target_x       <= r.tx;
    in_ch.target_y       <= r.ty;
    in_ch.front_range_mm <= r.range_mm;
    do @(posedge clk); while (!in_ch.ready);
    pending_cmds.insert(pending_cmds.size(), typed ? typed_cmd : steer_command(r));
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned kind;
    r.rx = 10'($urandom);
    r.ry = 10'($urandom);
    r.tx = 10'($urandom);
    r.ty = 10'($urandom);
    r.hx = 11'($urandom);
    r.hy = 11'($urandom);
    r.range_mm = ($urandom_range(3) == 0) ? 12'($urandom_range(300)) : 12'($urandom);
    kind = $urandom_range(19);
    case (kind)
      0, 1: begin
        r.tx = r.rx;
        r.ty = r.ry;
      end
      2, 3: begin
        r.hx = '0;
        r.hy = '0;
      end
      4, 5, 6: begin
        // heading along or against the target direction
        r.hx = 11'($signed({1'b0, r.tx}) - $signed({1'b0, r.rx}));
        r.hy = 11'($signed({1'b0, r.ty}) - $signed({1'b0, r.ry}));
        if (kind == 5) begin
          r.hx = -r.hx;
          r.hy = -r.hy;
        end
      end
      7, 8: begin
        // small offsets and small headings give short vectors
        r.tx = r.rx ^ 10'($urandom_range(7));
        r.ty = r.ry ^ 10'($urandom_range(7));
        r.hx = 11'($signed(4'($urandom)));
        r.hy = 11'($signed(4'($urandom)));
      end
      default: ;
    endcase
    return r;
  endfunction

  table_row_t steer_table[$];

  function automatic table_row_t row(int rx, int ry, int hx, int hy, int tx, int ty,
                                     int rg, bit typed = 0, int rot = 0, int tr = 0,
                                     int ang = 0);
    table_row_t t;
    t.req.rx = 10'(rx); t.req.ry = 10'(ry); t.req.hx = 11'(hx); t.req.hy = 11'(hy);
    t.req.tx = 10'(tx); t.req.ty = 10'(ty); t.req.range_mm = 12'(rg);
    t.typed = typed;
    t.cmd.rot = ROT_W'(rot); t.cmd.trans = VEL_W'(tr); t.cmd.angle = ANGLE_W'(ang);
    return t;
  endfunction

  initial begin
    command_t none;
    request_t r;
    none = '{default: '0};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.robot_x = '0; in_ch.robot_y = '0; in_ch.heading_dx = '0;
    in_ch.heading_dy = '0; in_ch.target_x = '0; in_ch.target_y = '0;
    in_ch.front_range_mm = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    max_rot_q = MAX_ROT_RST;
    max_trans_q = MAX_TRANS_RST;
    divisor_q = DIVISOR_RST;
    stop_mm_q = STOP_RST;

    // target on the robot, zero heading, straight behind, blocked front, range at the stop threshold
    steer_table = {steer_table, row(100, 100, 5, 0, 100, 100, 4095, 1, 409, 410, 0)};
    steer_table = {steer_table, row(500, 600, 0, 0, 20, 900, 4095, 1, 409, 410, 0)};
    steer_table = {steer_table, row(100, 100, 1, 0, 50, 100, 4095, 1, 2048, 0, 25723)};
    steer_table = {steer_table, row(100, 100, 1, 0, 50, 100, 0, 1, 2048, 0, 25723)};
    steer_table = {steer_table, row(0, 0, 1023, 0, 1023, 0, 150, 1, 409, 410, 0)};
    steer_table = {steer_table, row(0, 0, 1023, 0, 1023, 0, 149, 1, 409, 0, 0)};
    steer_table = {steer_table, row(0, 0, -1024, -1024, 1023, 1023, 4095)};
    steer_table = {steer_table, row(1023, 1023, -1024, 1023, 0, 0, 4095)};
    steer_table = {steer_table, row(1023, 0, 1023, -1024, 0, 1023, 2000)};
    steer_table = {steer_table, row(0, 1023, 0, 1023, 1023, 1023, 4095)};
    steer_table = {steer_table, row(512, 512, 0, 1, 513, 512, 4095)};
    steer_table = {steer_table, row(512, 512, 0, -1, 513, 512, 4095)};
    steer_table = {steer_table, row(512, 512, 10, 3, 600, 540, 4095)};
    steer_table = {steer_table, row(512, 512, 10, -3, 600, 480, 300)};
    steer_table = {steer_table, row(512, 512, -7, 2, 400, 530, 4095)};
    steer_table = {steer_table, row(300, 700, 3, 4, 303, 704, 4095)};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer_table[i])
      send_request(steer_table[i].req, steer_table[i].typed, steer_table[i].cmd);

    for (int phase = 0; phase < 5; phase++) begin
      in_ch.valid <= 1'b0;
      drain();
      case (phase)
        0: apply_settings(13'd8191, 13'd8191, 4'd15, 12'd4095);
        1: apply_settings(13'd0, 13'd0, 4'd0, 12'd0);
        2: apply_settings(13'd4096, 13'd4096, 4'd1, 12'd150);
        default: apply_settings(13'($urandom_range(4096)), 13'($urandom_range(4096)),
                                4'($urandom_range(1, 15)), 12'($urandom));
      endcase
      case (phase)
        1: begin send_idle_pct = 84; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 84; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      @(posedge clk);
      for (int n = 0; n < 360; n++) begin
        // mixed idling inside phase 4 too
        if (phase == 4 && n % 90 == 0) begin
          send_idle_pct = $urandom_range(1) ? 84 : 0;
          recv_stall_pct = $urandom_range(1) ? 84 : 0;
        end
        r = random_request();
        send_request(r, 0, none);
      end
    end
    in_ch.valid <= 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
